// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk outside reset.
`define LZ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define LZ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lz77d_pkg.sv =====
package lz77d_pkg;

  // Parser phases, one-hot.
  typedef enum logic [7:0] {
    PH_MAGIC = 8'b0000_0001,
    PH_SIZE0 = 8'b0000_0010,
    PH_SIZE1 = 8'b0000_0100,
    PH_SIZE2 = 8'b0000_1000,
    PH_FLAG  = 8'b0001_0000,
    PH_DATA  = 8'b0010_0000,
    PH_REF2  = 8'b0100_0000,
    PH_STOP  = 8'b1000_0000
  } phase_t;

  localparam logic [7:0] MAGIC_BYTE     = 8'h10;
  localparam logic [4:0] LEN_BIAS       = 5'd3;
  localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

  // One result word handed from the control to the output register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       bad;
  } emit_t;

endpackage

// ===== sv/lz77d_hist.sv =====
`include "assert_macros.svh"

module lz77d_hist #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  output logic [7:0]               rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

  logic [7:0] mem [DEPTH];
  logic [7:0] q_r;
  logic [AW:0] fill_r, fill_nxt;
  logic fwd_hit_r;
  logic [7:0] fwd_data_r;
  logic vld_r;

  // Writes only ever land at or below the fill mark, so every entry below
  // it has been written since reset and every entry above it still reads zero.
  always_comb begin
    fill_nxt = fill_r;
    if (wr_en && fill_r != DEPTH_W && (AW+1)'(wr_addr) == fill_r) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_hit_r  <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
      vld_r      <= (AW+1)'(rd_addr) < fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : (vld_r ? q_r : 8'd0);

  `LZ_ASSERT(a_wr_below_fill, wr_en |-> ((AW+1)'(wr_addr) <= fill_r), "write beyond fill mark")

endmodule

// ===== sv/lz77d_ctrl.sv =====
`include "assert_macros.svh"

module lz77d_ctrl #(
  parameter int DEPTH = 4096,
  parameter int SB    = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_byte,
  input  logic                     in_stream_start,
  input  logic                     out_free,
  output lz77d_pkg::emit_t         emit,
  output logic                     rd_en,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic                     wr_en,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output logic [7:0]               wr_data,
  input  logic [7:0]               rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] PTR_MAX = AW'(DEPTH - 1);

  lz77d_pkg::phase_t phase_r, phase_nxt, ph_b;
  logic [SB-1:0] ds_r, ds_nxt, ds_b;
  logic [SB-1:0] pc_r, pc_nxt, pc_b, pc_new;
  logic [7:0]    fb_r, fb_nxt, fb_b;
  logic [3:0]    fr_r, fr_nxt, fr_b, fr_dec;
  logic [7:0]    ref_r, ref_nxt, ref_b;
  logic [AW-1:0] wp_r, wp_nxt, wp_b;
  logic [AW-1:0] src_r, src_nxt;
  logic [4:0]    rd_left_r, rd_left_nxt;
  logic          copy_busy_r, copy_busy_nxt;
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_last_r, s1_last_nxt;
  logic          acc, s1_move, reached;
  logic [31:0]   size_w;
  logic [12:0]   ref_dist;
  logic [AW:0]   src_sum;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == PTR_MAX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SB-1:0] sat_inc(input logic [SB-1:0] c);
    sat_inc = (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic lz77d_pkg::phase_t after_flag(input logic done_now,
                                                   input logic [3:0] left);
    if (done_now) begin
      after_flag = lz77d_pkg::PH_STOP;
    end else if (left == 4'd0) begin
      after_flag = lz77d_pkg::PH_FLAG;
    end else begin
      after_flag = lz77d_pkg::PH_DATA;
    end
  endfunction

  assign in_stall = copy_busy_r || !out_free;
  assign acc      = in_valid && !in_stall;
  assign s1_move  = s1_valid_r && out_free;

  // A new stream starts from cleared parser state.
  assign ph_b  = in_stream_start ? lz77d_pkg::PH_MAGIC : phase_r;
  assign ds_b  = in_stream_start ? '0 : ds_r;
  assign pc_b  = in_stream_start ? '0 : pc_r;
  assign fb_b  = in_stream_start ? 8'd0 : fb_r;
  assign fr_b  = in_stream_start ? 4'd0 : fr_r;
  assign ref_b = in_stream_start ? 8'd0 : ref_r;
  assign wp_b  = in_stream_start ? '0 : wp_r;

  always_comb begin
    phase_nxt     = phase_r;
    ds_nxt        = ds_r;
    pc_nxt        = pc_r;
    fb_nxt        = fb_r;
    fr_nxt        = fr_r;
    ref_nxt       = ref_r;
    wp_nxt        = wp_r;
    src_nxt       = src_r;
    rd_left_nxt   = rd_left_r;
    copy_busy_nxt = copy_busy_r;
    s1_valid_nxt  = s1_valid_r;
    s1_last_nxt   = s1_last_r;
    emit          = '0;
    rd_en         = 1'b0;
    rd_addr       = src_r;
    wr_en         = 1'b0;
    wr_addr       = wp_r;
    wr_data       = in_byte;
    pc_new        = sat_inc(pc_b);
    fr_dec        = (fr_b != 4'd0) ? fr_b - 1'b1 : 4'd0;
    reached       = 1'b0;
    size_w        = 32'(ds_b);
    ref_dist      = {ref_b[3:0], in_byte} + 13'd1;
    src_sum       = {1'b0, wp_b} + DEPTH_W - (AW+1)'(ref_dist);
    if (src_sum >= DEPTH_W) begin
      src_sum = src_sum - DEPTH_W;
    end

    if (acc) begin
      phase_nxt = ph_b;
      ds_nxt    = ds_b;
      pc_nxt    = pc_b;
      fb_nxt    = fb_b;
      fr_nxt    = fr_b;
      ref_nxt   = ref_b;
      wp_nxt    = wp_b;
      case (ph_b)
        lz77d_pkg::PH_MAGIC: begin
          if (in_byte != lz77d_pkg::MAGIC_BYTE) begin
            emit.valid = 1'b1;
            emit.last  = 1'b1;
            emit.bad   = 1'b1;
            phase_nxt  = lz77d_pkg::PH_STOP;
          end else begin
            ds_nxt    = '0;
            phase_nxt = lz77d_pkg::PH_SIZE0;
          end
        end
        lz77d_pkg::PH_SIZE0: begin
          size_w    = 32'(in_byte);
          ds_nxt    = size_w[SB-1:0];
          phase_nxt = lz77d_pkg::PH_SIZE1;
        end
        lz77d_pkg::PH_SIZE1: begin
          size_w    = 32'(ds_b) | (32'(in_byte) << 8);
          ds_nxt    = size_w[SB-1:0];
          phase_nxt = lz77d_pkg::PH_SIZE2;
        end
        lz77d_pkg::PH_SIZE2: begin
          size_w    = 32'(ds_b) | (32'(in_byte) << 16);
          ds_nxt    = size_w[SB-1:0];
          phase_nxt = (pc_b >= size_w[SB-1:0]) ? lz77d_pkg::PH_STOP
                                               : lz77d_pkg::PH_FLAG;
        end
        lz77d_pkg::PH_FLAG: begin
          fb_nxt    = in_byte;
          fr_nxt    = lz77d_pkg::FLAGS_PER_BYTE;
          phase_nxt = lz77d_pkg::PH_DATA;
        end
        lz77d_pkg::PH_DATA: begin
          if (!fb_b[7]) begin
            reached    = pc_new >= ds_b;
            wr_en      = 1'b1;
            wr_addr    = wp_b;
            wr_data    = in_byte;
            wp_nxt     = ptr_inc(wp_b);
            pc_nxt     = pc_new;
            emit.valid = 1'b1;
            emit.data  = in_byte;
            emit.last  = 1'b1;
            emit.done  = reached;
            fb_nxt     = {fb_b[6:0], 1'b0};
            fr_nxt     = fr_dec;
            phase_nxt  = after_flag(reached, fr_dec);
          end else begin
            ref_nxt   = in_byte;
            phase_nxt = lz77d_pkg::PH_REF2;
          end
        end
        lz77d_pkg::PH_REF2: begin
          src_nxt       = src_sum[AW-1:0];
          rd_left_nxt   = {1'b0, ref_b[7:4]} + lz77d_pkg::LEN_BIAS;
          copy_busy_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // Copy sequencer: while out_free is high, read one history byte per
    // cycle and write it back at the write pointer as the output takes it.
    if (copy_busy_r) begin
      rd_en = (rd_left_r != 5'd0) && (!s1_valid_r || s1_move);
      if (rd_en) begin
        src_nxt      = ptr_inc(src_r);
        rd_left_nxt  = rd_left_r - 1'b1;
        s1_last_nxt  = (rd_left_r == 5'd1);
        s1_valid_nxt = 1'b1;
      end else if (s1_move) begin
        s1_valid_nxt = 1'b0;
      end
      if (s1_move) begin
        pc_new     = sat_inc(pc_r);
        reached    = pc_new >= ds_r;
        wr_en      = 1'b1;
        wr_addr    = wp_r;
        wr_data    = rd_data;
        wp_nxt     = ptr_inc(wp_r);
        pc_nxt     = pc_new;
        emit.valid = 1'b1;
        emit.data  = rd_data;
        emit.last  = s1_last_r;
        emit.done  = reached;
        if (s1_last_r) begin
          fr_dec        = (fr_r != 4'd0) ? fr_r - 1'b1 : 4'd0;
          fb_nxt        = {fb_r[6:0], 1'b0};
          fr_nxt        = fr_dec;
          phase_nxt     = after_flag(reached, fr_dec);
          copy_busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lz77d_pkg::PH_MAGIC;
      ds_r        <= '0;
      pc_r        <= '0;
      fb_r        <= 8'd0;
      fr_r        <= 4'd0;
      ref_r       <= 8'd0;
      wp_r        <= '0;
      rd_left_r   <= 5'd0;
      copy_busy_r <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      ds_r        <= ds_nxt;
      pc_r        <= pc_nxt;
      fb_r        <= fb_nxt;
      fr_r        <= fr_nxt;
      ref_r       <= ref_nxt;
      wp_r        <= wp_nxt;
      rd_left_r   <= rd_left_nxt;
      copy_busy_r <= copy_busy_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r     <= src_nxt;
    s1_last_r <= s1_last_nxt;
  end

  `LZ_ASSERT(a_s1_in_copy, s1_valid_r |-> copy_busy_r, "read stage busy outside a copy")
  `LZ_ASSERT(a_left_in_copy, (rd_left_r != 5'd0) |-> copy_busy_r, "copy bytes left while idle")

endmodule

// ===== sv/lz77_type10_stream_decoder.sv =====
// A literal word reaches the output in the cycle after its input word is taken;
// a back-reference of L bytes (3 to 18) is copied one byte per cycle while the
// output is free, and input stalls until its last byte is handed on. Header,
// flag and first reference words are taken one per cycle while output is free.
// Reset (rst_n low, synchronous) clears the parser and the history fill mark,
// so the whole window reads as zeros at once with no clearing pass.
`include "assert_macros.svh"

module lz77_type10_stream_decoder #(
  parameter int WINDOW_DEPTH = 4096,
  parameter int SIZE_BITS    = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_stream_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_stream_done,
  output logic       out_bad_header
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  // The control block decodes the header and flag words and sequences
  // back-reference copies through the history memory. Each decoded byte is
  // written back into the window in the same cycle it is handed to the
  // output register, so the memory alone carries the sliding window.
  lz77d_pkg::emit_t emit;
  logic          out_free;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_data, rd_data;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_run_last_r, out_stream_done_r, out_bad_header_r;

  // The output register can take a new word when it is empty or its word
  // is being taken this cycle; the control only produces a word then.
  assign out_free = !out_valid_r || !out_stall;

  lz77d_ctrl #(
    .DEPTH (WINDOW_DEPTH),
    .SB    (SIZE_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_stream_start (in_stream_start),
    .out_free        (out_free),
    .emit            (emit),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_data         (rd_data)
  );

  // History window: one write and one registered read per cycle. A read of
  // the byte being written in the same cycle, which happens when the copy
  // distance is one, is forwarded inside the memory block.
  lz77d_hist #(
    .DEPTH (WINDOW_DEPTH)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // The payload needs no reset; it is only loaded along with a valid word.
  always_ff @(posedge clk) begin
    if (out_free && emit.valid) begin
      out_byte_r        <= emit.data;
      out_run_last_r    <= emit.last;
      out_stream_done_r <= emit.done;
      out_bad_header_r  <= emit.bad;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_run_last    = out_run_last_r;
  assign out_stream_done = out_stream_done_r;
  assign out_bad_header  = out_bad_header_r;

  `LZ_ASSERT(a_emit_has_room, emit.valid |-> out_free, "word produced while output is full")
  `LZ_ASSERT(a_bad_alone, (out_valid_r && out_bad_header_r) |-> (out_run_last_r && (out_byte_r == 8'd0)), "malformed error word")
  `LZ_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule
